// ===== rtl/multitouch_contact_tracker_macros.svh =====
// ----------------------------------------------------------------------------
// multitouch_contact_tracker_macros
// Assertion macros shared by the contact tracker modules.
// ----------------------------------------------------------------------------
`ifndef MULTITOUCH_CONTACT_TRACKER_MACROS_SVH
`define MULTITOUCH_CONTACT_TRACKER_MACROS_SVH
`ifndef ASSERT_OFF
`define MCT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define MCT_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MCT_ASSERT(lbl, clk, rst, prop, msg)
`define MCT_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/mct_pkg.sv =====
// ----------------------------------------------------------------------------
// mct_pkg
// Shared types and constants of the contact tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mct_pkg;
  localparam int TouchSlots    = 32;
  localparam int PenSlots      = 4;
  localparam int BatchCapacity = 64;
  localparam logic [8:0] TouchBase = 9'd100;
  localparam logic [8:0] PenBase   = 9'd500;
  localparam logic [6:0] FullPct   = 7'd100;

  typedef enum logic [2:0] {
    REQ_T_PRESS = 3'd0, REQ_T_UPDATE = 3'd1, REQ_T_RELEASE = 3'd2,
    REQ_P_PRESS = 3'd3, REQ_P_UPDATE = 3'd4, REQ_P_RELEASE = 3'd5,
    REQ_CANCEL = 3'd6, REQ_NONE = 3'd7
  } req_t;

  typedef enum logic [2:0] {
    PH_ADD = 3'd0, PH_DOWN = 3'd1, PH_MOVE = 3'd2,
    PH_UP = 3'd3, PH_CANCEL = 3'd4, PH_REMOVE = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    CMD_STATUS, CMD_TOUCH, CMD_PEN, CMD_CANCEL
  } cmd_t;

  // classified command handed from front to back
  typedef struct packed {
    cmd_t        cmd;
    logic        is_press;
    logic        is_update;
    logic [15:0] src;
    logic [15:0] x;
    logic [15:0] y;
    logic [6:0]  force_pct;
    logic [47:0] time_us;
  } cmd_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EMIT_A, ST_EMIT_B, ST_SCAN, ST_STATUS
  } st_t;

  function automatic logic [6:0] clamp_pct(input logic [15:0] lvl);
    if (lvl[15]) return 7'd0;
    if (lvl > 16'd100) return FullPct;
    return lvl[6:0];
  endfunction
endpackage
`default_nettype wire

// ===== rtl/mct_front.sv =====
// ----------------------------------------------------------------------------
// mct_front
// Accepts raw items, classifies them and pushes commands into a 2-deep queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "multitouch_contact_tracker_macros.svh"
module mct_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             touch_en,
  input  wire logic             pen_en,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [2:0]       req_type,
  input  wire logic [15:0]      source_id,
  input  wire logic [15:0]      pos_x,
  input  wire logic [15:0]      pos_y,
  input  wire logic [15:0]      pen_level,
  input  wire logic [47:0]      time_us,
  output logic                  q_valid,
  input  wire logic             q_ready,
  output mct_pkg::cmd_item_t    q_item
);
  mct_pkg::cmd_item_t mem [2];
  logic       wptr, rptr;
  logic [1:0] count;
  mct_pkg::cmd_item_t c;
  logic push, pop;

  always_comb begin
    c = '0;
    c.src = source_id;
    c.x = pos_x;
    c.y = pos_y;
    c.force_pct = mct_pkg::clamp_pct(pen_level);
    c.time_us = time_us;
    c.cmd = mct_pkg::CMD_STATUS;
    case (mct_pkg::req_t'(req_type))
      mct_pkg::REQ_T_PRESS, mct_pkg::REQ_T_UPDATE, mct_pkg::REQ_T_RELEASE:
        if (touch_en) c.cmd = mct_pkg::CMD_TOUCH;
      mct_pkg::REQ_P_PRESS, mct_pkg::REQ_P_UPDATE, mct_pkg::REQ_P_RELEASE:
        if (pen_en) c.cmd = mct_pkg::CMD_PEN;
      mct_pkg::REQ_CANCEL: c.cmd = mct_pkg::CMD_CANCEL;
      default: c.cmd = mct_pkg::CMD_STATUS;
    endcase
    c.is_press  = (req_type == mct_pkg::REQ_T_PRESS) || (req_type == mct_pkg::REQ_P_PRESS);
    c.is_update = (req_type == mct_pkg::REQ_T_UPDATE) || (req_type == mct_pkg::REQ_P_UPDATE);
  end

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_item = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= c;
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `MCT_ASSERT(a_no_overflow, clk, rst, push |-> count != 2'd2, "queue overflow")
  `MCT_ASSERT(a_count_step, clk, rst, (push && !pop) |=> count == $past(count) + 2'd1, "count")
  `MCT_ASSERT(a_no_underflow, clk, rst, pop |-> count != 2'd0, "queue underflow")
endmodule
`default_nettype wire

// ===== rtl/mct_back.sv =====
// ----------------------------------------------------------------------------
// mct_back
// Contact table and event sequencer; emits results through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "multitouch_contact_tracker_macros.svh"
module mct_back #(
  parameter int TOUCH_SLOTS    = mct_pkg::TouchSlots,
  parameter int PEN_SLOTS      = mct_pkg::PenSlots,
  parameter int BATCH_CAPACITY = mct_pkg::BatchCapacity
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  output logic                  q_ready,
  input  wire mct_pkg::cmd_item_t q_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  event_valid,
  output logic [2:0]            phase,
  output logic [8:0]            device_number,
  output logic                  is_stylus,
  output logic [15:0]           out_x,
  output logic [15:0]           out_y,
  output logic [6:0]            pressure_pct,
  output logic [47:0]           out_time_us,
  output logic                  touch_held,
  output logic                  pen_held,
  output logic                  last
);
  localparam int TW = (TOUCH_SLOTS > 1) ? $clog2(TOUCH_SLOTS) : 1;
  localparam int PW = (PEN_SLOTS > 1) ? $clog2(PEN_SLOTS) : 1;
  localparam int NS = TOUCH_SLOTS + PEN_SLOTS;
  localparam int SW = $clog2(NS + 1);
  localparam int BW = $clog2(BATCH_CAPACITY + 1);

  logic [TOUCH_SLOTS-1:0] t_used;
  logic [15:0] t_src [TOUCH_SLOTS];
  logic [15:0] t_x   [TOUCH_SLOTS];
  logic [15:0] t_y   [TOUCH_SLOTS];
  logic [PEN_SLOTS-1:0] p_used;
  logic [15:0] p_src [PEN_SLOTS];
  logic [15:0] p_x   [PEN_SLOTS];
  logic [15:0] p_y   [PEN_SLOTS];
  logic [6:0]  p_f   [PEN_SLOTS];

  mct_pkg::st_t st, st_next;
  mct_pkg::cmd_item_t cur;
  logic        pen_k;
  logic [PW+TW-1:0] slot_r;
  logic        two_ev;
  logic [SW-1:0] scan;
  logic [BW-1:0] emitted;

  // lookup of the queue head
  logic       t_hit, t_free, p_hit, p_free;
  logic [TW-1:0] t_hit_i, t_free_i;
  logic [PW-1:0] p_hit_i, p_free_i;
  always_comb begin
    t_hit = 1'b0; t_free = 1'b0; t_hit_i = '0; t_free_i = '0;
    for (int i = TOUCH_SLOTS - 1; i >= 0; i--) begin
      if (t_used[i] && t_src[i] == q_item.src) begin t_hit = 1'b1; t_hit_i = TW'(i); end
      if (!t_used[i]) begin t_free = 1'b1; t_free_i = TW'(i); end
    end
    p_hit = 1'b0; p_free = 1'b0; p_hit_i = '0; p_free_i = '0;
    for (int i = PEN_SLOTS - 1; i >= 0; i--) begin
      if (p_used[i] && p_src[i] == q_item.src) begin p_hit = 1'b1; p_hit_i = PW'(i); end
      if (!p_used[i]) begin p_free = 1'b1; p_free_i = PW'(i); end
    end
  end

  logic ob_free;
  assign ob_free = !out_valid || out_ready;
  assign q_ready = (st == mct_pkg::ST_IDLE);

  // next used slot at or after scan
  logic          sc_found;
  logic [SW-1:0] sc_idx;
  always_comb begin
    sc_found = 1'b0; sc_idx = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (SW'(i) >= scan) begin
        if (i < TOUCH_SLOTS) begin
          if (t_used[i]) begin sc_found = 1'b1; sc_idx = SW'(i); end
        end else if (p_used[i - TOUCH_SLOTS]) begin
          sc_found = 1'b1; sc_idx = SW'(i);
        end
      end
    end
  end

  logic [TW-1:0] st_i;
  logic [PW-1:0] sp_i;
  assign st_i = slot_r[TW-1:0];
  assign sp_i = slot_r[PW+TW-1:TW];

  // result builder
  logic        r_ev, r_last, r_stylus;
  logic [2:0]  r_ph;
  logic [8:0]  r_dev;
  logic [15:0] r_x, r_y;
  logic [6:0]  r_pct;
  logic        emit;
  logic        t_clr, p_clr;
  logic [TW-1:0] tci;
  logic [PW-1:0] pci;
  logic        sc_pen;
  logic [SW-1:0] sc_next;
  logic [TW-1:0] sc_ti;
  logic [PW-1:0] sc_pi;

  always_comb begin
    st_next = st;
    r_ev = 1'b1; r_last = 1'b0; r_stylus = pen_k; r_ph = mct_pkg::PH_ADD;
    r_dev = pen_k ? mct_pkg::PenBase + 9'(sp_i) : mct_pkg::TouchBase + 9'(st_i);
    r_x = pen_k ? p_x[sp_i] : t_x[st_i];
    r_y = pen_k ? p_y[sp_i] : t_y[st_i];
    r_pct = 7'd0;
    emit = 1'b0; t_clr = 1'b0; p_clr = 1'b0; tci = st_i; pci = sp_i;
    sc_pen = (sc_idx >= SW'(TOUCH_SLOTS));
    sc_ti = sc_idx[TW-1:0];
    sc_pi = PW'(sc_idx - SW'(TOUCH_SLOTS));
    sc_next = sc_idx;
    case (st)
      mct_pkg::ST_EMIT_A: begin
        if (ob_free) begin
          emit = 1'b1;
          if (!two_ev) begin
            r_ph = mct_pkg::PH_MOVE;
            r_pct = pen_k ? p_f[sp_i] : mct_pkg::FullPct;
            r_last = 1'b1;
            st_next = mct_pkg::ST_IDLE;
          end else begin
            r_ph = cur.is_press ? mct_pkg::PH_ADD : mct_pkg::PH_UP;
            // release: free the slot now so both results carry the final flags
            t_clr = !cur.is_press && !pen_k;
            p_clr = !cur.is_press && pen_k;
            st_next = mct_pkg::ST_EMIT_B;
          end
        end
      end
      mct_pkg::ST_EMIT_B: begin
        if (ob_free) begin
          emit = 1'b1; r_last = 1'b1; st_next = mct_pkg::ST_IDLE;
          if (cur.is_press) begin
            r_ph = mct_pkg::PH_DOWN;
            r_pct = pen_k ? p_f[sp_i] : mct_pkg::FullPct;
          end else begin
            r_ph = mct_pkg::PH_REMOVE;
          end
        end
      end
      mct_pkg::ST_SCAN: begin
        r_stylus = sc_pen;
        r_dev = sc_pen ? mct_pkg::PenBase + 9'(sc_pi) : mct_pkg::TouchBase + 9'(sc_ti);
        r_x = sc_pen ? p_x[sc_pi] : t_x[sc_ti];
        r_y = sc_pen ? p_y[sc_pi] : t_y[sc_ti];
        if (!sc_found) begin
          st_next = mct_pkg::ST_STATUS;
        end else if (ob_free) begin
          emit = 1'b1;
          r_ph = two_ev ? mct_pkg::PH_REMOVE : mct_pkg::PH_CANCEL;
          if (two_ev) begin
            t_clr = !sc_pen; p_clr = sc_pen; tci = sc_ti; pci = sc_pi;
          end
        end
      end
      mct_pkg::ST_STATUS: begin
        r_ev = 1'b0; r_stylus = 1'b0; r_dev = '0; r_x = '0; r_y = '0;
        r_last = 1'b1;
        if (ob_free) begin
          emit = 1'b1; st_next = mct_pkg::ST_IDLE;
        end
      end
      default: st_next = st;
    endcase
  end

  // flags after this item's clear
  logic [TOUCH_SLOTS-1:0] t_used_n;
  logic [PEN_SLOTS-1:0]   p_used_n;
  always_comb begin
    t_used_n = t_used;
    p_used_n = p_used;
    if (t_clr) t_used_n[tci] = 1'b0;
    if (p_clr) p_used_n[pci] = 1'b0;
  end

  // results beyond BATCH_CAPACITY for this item are dropped
  logic drop;
  assign drop = (emitted >= BW'(BATCH_CAPACITY));

  // load the output register; status only when the item made no event
  logic load;
  assign load = emit && ((st == mct_pkg::ST_STATUS) ? (emitted == '0) : !drop);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= mct_pkg::ST_IDLE;
      t_used <= '0;
      p_used <= '0;
      out_valid <= 1'b0;
      emitted <= '0;
      two_ev <= 1'b0;
      scan <= '0;
      pen_k <= 1'b0;
      slot_r <= '0;
    end else begin
      out_valid <= load || (out_valid && !out_ready);
      if (q_valid && q_ready) begin
        emitted <= '0;
        scan <= '0;
        cur <= q_item;
        case (q_item.cmd)
          mct_pkg::CMD_TOUCH: begin
            pen_k <= 1'b0;
            if (t_hit) begin
              slot_r <= (PW+TW)'(t_hit_i);
              t_x[t_hit_i] <= q_item.x;
              t_y[t_hit_i] <= q_item.y;
              two_ev <= !(q_item.is_press || q_item.is_update);
              st <= mct_pkg::ST_EMIT_A;
            end else if (q_item.is_press && t_free) begin
              slot_r <= (PW+TW)'(t_free_i);
              t_used[t_free_i] <= 1'b1;
              t_src[t_free_i] <= q_item.src;
              t_x[t_free_i] <= q_item.x;
              t_y[t_free_i] <= q_item.y;
              two_ev <= 1'b1;
              st <= mct_pkg::ST_EMIT_A;
            end else begin
              two_ev <= 1'b0;
              st <= mct_pkg::ST_STATUS;
            end
          end
          mct_pkg::CMD_PEN: begin
            pen_k <= 1'b1;
            if (p_hit) begin
              slot_r <= {p_hit_i, TW'(0)};
              p_x[p_hit_i] <= q_item.x;
              p_y[p_hit_i] <= q_item.y;
              if (q_item.is_press || q_item.is_update) p_f[p_hit_i] <= q_item.force_pct;
              two_ev <= !(q_item.is_press || q_item.is_update);
              st <= mct_pkg::ST_EMIT_A;
            end else if (q_item.is_press && p_free) begin
              slot_r <= {p_free_i, TW'(0)};
              p_used[p_free_i] <= 1'b1;
              p_src[p_free_i] <= q_item.src;
              p_x[p_free_i] <= q_item.x;
              p_y[p_free_i] <= q_item.y;
              p_f[p_free_i] <= q_item.force_pct;
              two_ev <= 1'b1;
              st <= mct_pkg::ST_EMIT_A;
            end else begin
              two_ev <= 1'b0;
              st <= mct_pkg::ST_STATUS;
            end
          end
          mct_pkg::CMD_CANCEL: begin
            two_ev <= 1'b0;
            st <= mct_pkg::ST_SCAN;
          end
          default: begin
            two_ev <= 1'b0;
            st <= mct_pkg::ST_STATUS;
          end
        endcase
      end else begin
        st <= st_next;
        t_used <= t_used_n;
        p_used <= p_used_n;
        if (emit && !drop && st != mct_pkg::ST_STATUS) emitted <= emitted + BW'(1);
        if (st == mct_pkg::ST_SCAN && emit) begin
          two_ev <= !two_ev;
          if (two_ev) scan <= sc_next + SW'(1);
        end
      end
    end
  end

  // output register; in a cancel scan the last remove is flagged by lookahead
  logic scan_last;
  always_comb begin
    scan_last = 1'b0;
    if (st == mct_pkg::ST_SCAN && two_ev) begin
      scan_last = 1'b1;
      for (int i = 0; i < NS; i++)
        if (SW'(i) > sc_idx) begin
          if (i < TOUCH_SLOTS) begin
            if (t_used[i]) scan_last = 1'b0;
          end else if (p_used[i - TOUCH_SLOTS]) scan_last = 1'b0;
        end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      event_valid <= r_ev;
      phase <= r_ph;
      device_number <= r_dev;
      is_stylus <= r_stylus;
      out_x <= r_x;
      out_y <= r_y;
      pressure_pct <= r_pct;
      out_time_us <= cur.time_us;
      // a cancel leaves the whole table empty
      touch_held <= (st == mct_pkg::ST_SCAN) ? 1'b0 : |t_used_n;
      pen_held <= (st == mct_pkg::ST_SCAN) ? 1'b0 : |p_used_n;
      last <= r_last || scan_last || (emitted == BW'(BATCH_CAPACITY - 1));
    end
  end

  `MCT_ASSERT(a_hold_out, clk, rst, (out_valid && !out_ready) |=> out_valid, "result lost")
  `MCT_ASSERT(a_take_idle, clk, rst, (q_valid && q_ready) |-> st == mct_pkg::ST_IDLE, "busy take")
  `MCT_ASSERT(a_emit_room, clk, rst, emit |-> ob_free, "overwrite")
endmodule
`default_nettype wire

// ===== rtl/multitouch_contact_tracker.sv =====
// ----------------------------------------------------------------------------
// multitouch_contact_tracker
// Tracks touch and pen contacts and emits pointer events per raw event.
// ----------------------------------------------------------------------------
// Usage: raw events enter on in_valid/in_ready with req_type, source_id,
// pos_x, pos_y, pen_level and time_us. Each item gives one or more results
// on out_valid/out_ready; last marks the final one of the item.
// A front stage classifies items into a two-entry queue; the back stage
// owns the contact table and sequences the events.
// An input transfer passes the queue, the back stage's state and the output
// register. A press, update or release holds the back stage for a lookup plus
// one state per result; cancel-all emits a cancel and a remove per active
// contact, then visits the status state. The back sequencer, one result per
// cycle while the receiver is ready, sets the rate.
// Reset clears the table and sets both enables. When the receiver stalls,
// the output register holds and the queue fills, then in_ready drops.
// Write the configuration only while no item is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module multitouch_contact_tracker #(
  parameter int TOUCH_SLOTS    = mct_pkg::TouchSlots,
  parameter int PEN_SLOTS      = mct_pkg::PenSlots,
  parameter int BATCH_CAPACITY = mct_pkg::BatchCapacity
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  req_type,
  input  wire logic [15:0] source_id,
  input  wire logic [15:0] pos_x,
  input  wire logic [15:0] pos_y,
  input  wire logic [15:0] pen_level,
  input  wire logic [47:0] time_us,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             event_valid,
  output logic [2:0]       phase,
  output logic [8:0]       device_number,
  output logic             is_stylus,
  output logic [15:0]      out_x,
  output logic [15:0]      out_y,
  output logic [6:0]       pressure_pct,
  output logic [47:0]      out_time_us,
  output logic             touch_held,
  output logic             pen_held,
  output logic             last
);
  logic touch_enable, pen_enable;
  logic q_valid, q_ready;
  mct_pkg::cmd_item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      touch_enable <= 1'b1;
      pen_enable <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index) pen_enable <= cfg_data;
      else touch_enable <= cfg_data;
    end
  end

  mct_front u_front (
    .clk, .rst, .touch_en(touch_enable), .pen_en(pen_enable),
    .in_valid, .in_ready, .req_type, .source_id, .pos_x, .pos_y,
    .pen_level, .time_us, .q_valid, .q_ready, .q_item
  );

  mct_back #(
    .TOUCH_SLOTS(TOUCH_SLOTS), .PEN_SLOTS(PEN_SLOTS),
    .BATCH_CAPACITY(BATCH_CAPACITY)
  ) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item, .out_valid, .out_ready,
    .event_valid, .phase, .device_number, .is_stylus, .out_x, .out_y,
    .pressure_pct, .out_time_us, .touch_held, .pen_held, .last
  );
endmodule
`default_nettype wire

// ===== bench/multitouch_contact_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// multitouch_contact_tracker_tb
// Drives raw touch, pen and cancel events through the contact tracker, with
// random idle cycles on both sides. A behavioral copy of the contact table
// predicts every pointer and status result, and a checker compares each
// result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module multitouch_contact_tracker_tb;
  localparam int NumTouch = mct_pkg::TouchSlots;
  localparam int NumPen   = mct_pkg::PenSlots;
  localparam int MaxBatch = mct_pkg::BatchCapacity;
  localparam logic CfgTouchEnable = 1'b0;
  localparam logic CfgPenEnable   = 1'b1;

  typedef struct packed {
    logic        ev;
    mct_pkg::phase_t ph;
    logic [8:0]  dev;
    logic        stylus;
    logic [15:0] x;
    logic [15:0] y;
    logic [6:0]  pct;
    logic [47:0] ts;
    logic        t_act;
    logic        p_act;
    logic        lst;
  } pointer_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0, cfg_index = 1'b0, cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] req_type = '0;
  logic [15:0] source_id = '0, pos_x = '0, pos_y = '0, pen_level = '0;
  logic [47:0] time_us = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic event_valid, is_stylus, touch_held, pen_held, last;
  logic [2:0] phase;
  logic [8:0] device_number;
  logic [15:0] out_x, out_y;
  logic [6:0] pressure_pct;
  logic [47:0] out_time_us;

  multitouch_contact_tracker dut (.*);

  always #5 clk = ~clk;

  // contact table copy
  logic        touch_on;
  logic        pen_on;
  logic        t_used [NumTouch];
  logic [15:0] t_src  [NumTouch];
  logic [15:0] t_x    [NumTouch];
  logic [15:0] t_y    [NumTouch];
  logic        p_used [NumPen];
  logic [15:0] p_src  [NumPen];
  logic [15:0] p_x    [NumPen];
  logic [15:0] p_y    [NumPen];
  logic [6:0]  p_frc  [NumPen];

  pointer_event_t pending_events[$];
  int errors = 0;
  bit no_idle = 1'b0;

  function automatic logic [6:0] pressure_of(logic [15:0] lvl);
    if (lvl[15]) return 7'd0;
    if (lvl > 16'd100) return 7'd100;
    return lvl[6:0];
  endfunction

  task automatic track_event(input logic [2:0] rq, input logic [15:0] src,
                             input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] lvl, input logic [47:0] ts);
    pointer_event_t batch[$];
    pointer_event_t e;
    logic [6:0] f;
    int s;
    logic ta, pa;
    f = pressure_of(lvl);
    s = -1;
    e = '0;
    e.ev = 1'b1;
    e.ts = ts;
    if (rq <= mct_pkg::REQ_T_RELEASE && touch_on) begin
      for (int i = NumTouch - 1; i >= 0; i--) if (t_used[i] && t_src[i] == src) s = i;
      e.stylus = 1'b0;
      if (s >= 0) begin
        t_x[s] = x; t_y[s] = y;
        e.dev = mct_pkg::TouchBase + 9'(s); e.x = x; e.y = y;
        if (rq == mct_pkg::REQ_T_RELEASE) begin
          e.ph = mct_pkg::PH_UP; batch.push_back(e);
          e.ph = mct_pkg::PH_REMOVE; batch.push_back(e);
          t_used[s] = 1'b0;
        end else begin
          e.ph = mct_pkg::PH_MOVE; e.pct = 7'd100; batch.push_back(e);
        end
      end else if (rq == mct_pkg::REQ_T_PRESS) begin
        for (int i = NumTouch - 1; i >= 0; i--) if (!t_used[i]) s = i;
        if (s >= 0) begin
          t_used[s] = 1'b1; t_src[s] = src; t_x[s] = x; t_y[s] = y;
          e.dev = mct_pkg::TouchBase + 9'(s); e.x = x; e.y = y;
          e.ph = mct_pkg::PH_ADD; batch.push_back(e);
          e.ph = mct_pkg::PH_DOWN; e.pct = 7'd100; batch.push_back(e);
        end
      end
    end else if (rq >= mct_pkg::REQ_P_PRESS && rq <= mct_pkg::REQ_P_RELEASE && pen_on) begin
      for (int i = NumPen - 1; i >= 0; i--) if (p_used[i] && p_src[i] == src) s = i;
      e.stylus = 1'b1;
      if (s >= 0) begin
        p_x[s] = x; p_y[s] = y;
        e.dev = mct_pkg::PenBase + 9'(s); e.x = x; e.y = y;
        if (rq == mct_pkg::REQ_P_RELEASE) begin
          e.ph = mct_pkg::PH_UP; batch.push_back(e);
          e.ph = mct_pkg::PH_REMOVE; batch.push_back(e);
          p_used[s] = 1'b0;
        end else begin
          p_frc[s] = f;
          e.ph = mct_pkg::PH_MOVE; e.pct = f; batch.push_back(e);
        end
      end else if (rq == mct_pkg::REQ_P_PRESS) begin
        for (int i = NumPen - 1; i >= 0; i--) if (!p_used[i]) s = i;
        if (s >= 0) begin
          p_used[s] = 1'b1; p_src[s] = src; p_x[s] = x; p_y[s] = y; p_frc[s] = f;
          e.dev = mct_pkg::PenBase + 9'(s); e.x = x; e.y = y;
          e.ph = mct_pkg::PH_ADD; batch.push_back(e);
          e.ph = mct_pkg::PH_DOWN; e.pct = f; batch.push_back(e);
        end
      end
    end else if (rq == mct_pkg::REQ_CANCEL) begin
      for (int i = 0; i < NumTouch; i++) if (t_used[i]) begin
        e.stylus = 1'b0; e.dev = mct_pkg::TouchBase + 9'(i); e.x = t_x[i]; e.y = t_y[i];
        e.ph = mct_pkg::PH_CANCEL; batch.push_back(e);
        e.ph = mct_pkg::PH_REMOVE; batch.push_back(e);
        t_used[i] = 1'b0;
      end
      for (int i = 0; i < NumPen; i++) if (p_used[i]) begin
        e.stylus = 1'b1; e.dev = mct_pkg::PenBase + 9'(i); e.x = p_x[i]; e.y = p_y[i];
        e.ph = mct_pkg::PH_CANCEL; batch.push_back(e);
        e.ph = mct_pkg::PH_REMOVE; batch.push_back(e);
        p_used[i] = 1'b0;
      end
    end
    // drop events beyond the batch capacity
    while (batch.size() > MaxBatch) void'(batch.pop_back());
    if (batch.size() == 0) begin
      e = '0; e.ts = ts; batch.push_back(e);
    end
    ta = 1'b0; pa = 1'b0;
    foreach (t_used[i]) ta |= t_used[i];
    foreach (p_used[i]) pa |= p_used[i];
    foreach (batch[i]) begin
      batch[i].t_act = ta;
      batch[i].p_act = pa;
      batch[i].lst = (i == batch.size() - 1);
      pending_events.push_back(batch[i]);
    end
  endtask

  task automatic send_event(input mct_pkg::req_t rq, input logic [15:0] src,
                            input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] lvl);
    logic [47:0] ts;
    ts = 48'({$urandom, $urandom});
    while (!no_idle && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    track_event(rq, src, x, y, lvl, ts);
    in_valid <= 1'b1;
    req_type <= rq; source_id <= src; pos_x <= x; pos_y <= y;
    pen_level <= lvl; time_us <= ts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic val);
    drain();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgTouchEnable) touch_on = val; else pen_on = val;
  endtask

  // receiver stall
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= no_idle || ($urandom_range(99) >= 16);
  end

  always @(posedge clk) begin
    pointer_event_t want, got;
    if (!rst && out_valid && out_ready) begin
      got = '{event_valid, mct_pkg::phase_t'(phase), device_number, is_stylus, out_x,
              out_y, pressure_pct, out_time_us, touch_held, pen_held, last};
      if (pending_events.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer: %p", got);
      end else begin
        want = pending_events.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("result mismatch\n  exp %p\n  got %p", want, got);
        end
      end
    end
  end

  function automatic logic [15:0] rnd_coord();
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_event(mct_pkg::REQ_T_PRESS, 16'h0000, 16'h8000, 16'h7fff, 16'h0000);
    send_event(mct_pkg::REQ_T_PRESS, 16'hffff, 16'h7fff, 16'h8000, 16'hffff);
    send_event(mct_pkg::REQ_T_PRESS, 16'h0000, 16'h0001, 16'h0002, 16'h0000);
    send_event(mct_pkg::REQ_T_UPDATE, 16'hffff, 16'h1234, 16'hfedc, 16'h0000);
    send_event(mct_pkg::REQ_T_UPDATE, 16'h5555, 16'h0000, 16'h0000, 16'h0000);
    send_event(mct_pkg::REQ_T_RELEASE, 16'h0000, 16'hffff, 16'h0000, 16'h0000);
    send_event(mct_pkg::REQ_T_RELEASE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_event(mct_pkg::REQ_P_PRESS, 16'haaaa, 16'h0010, 16'h0020, 16'h8000);
    send_event(mct_pkg::REQ_P_PRESS, 16'haaaa, 16'h0011, 16'h0021, 16'd100);
    send_event(mct_pkg::REQ_P_UPDATE, 16'haaaa, 16'h0012, 16'h0022, 16'd101);
    send_event(mct_pkg::REQ_P_UPDATE, 16'haaaa, 16'h0013, 16'h0023, 16'h7fff);
    send_event(mct_pkg::REQ_P_UPDATE, 16'haaaa, 16'h0014, 16'h0024, 16'd55);
    send_event(mct_pkg::REQ_P_UPDATE, 16'h1111, 16'h0014, 16'h0024, 16'd55);
    for (int i = 0; i < 4; i++)
      send_event(mct_pkg::REQ_P_PRESS, 16'(i + 1), 16'(i), 16'(i), 16'($urandom));
    send_event(mct_pkg::REQ_P_RELEASE, 16'haaaa, 16'h0bad, 16'h0bad, 16'h0000);
    send_event(mct_pkg::REQ_NONE, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_event(mct_pkg::REQ_CANCEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_event(mct_pkg::REQ_CANCEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
  endtask

  // fill the touch table beyond its size and the pen table, then cancel everything
  task automatic test_full_table();
    for (int i = 0; i < NumTouch + 2; i++)
      send_event(mct_pkg::REQ_T_PRESS, 16'(16'h0200 + i), rnd_coord(), rnd_coord(),
                 16'h0000);
    for (int i = 0; i < NumPen; i++)
      send_event(mct_pkg::REQ_P_PRESS, 16'(16'h0300 + i), rnd_coord(), rnd_coord(),
                 16'($urandom));
    send_event(mct_pkg::REQ_CANCEL, 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom));
  endtask

  task automatic test_enables();
    write_cfg(CfgTouchEnable, 1'b0);
    write_cfg(CfgPenEnable, 1'b0);
    send_event(mct_pkg::REQ_T_PRESS, 16'h0042, 16'h0001, 16'h0001, 16'h0000);
    send_event(mct_pkg::REQ_P_PRESS, 16'h0042, 16'h0001, 16'h0001, 16'd50);
    send_event(mct_pkg::REQ_CANCEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    write_cfg(CfgPenEnable, 1'b1);
    send_event(mct_pkg::REQ_P_PRESS, 16'h0042, 16'h0001, 16'h0001, 16'd50);
    send_event(mct_pkg::REQ_T_PRESS, 16'h0042, 16'h0001, 16'h0001, 16'h0000);
    write_cfg(CfgTouchEnable, 1'b1);
    write_cfg(CfgPenEnable, 1'b0);
    send_event(mct_pkg::REQ_T_PRESS, 16'h0042, 16'h0002, 16'h0002, 16'h0000);
    send_event(mct_pkg::REQ_P_RELEASE, 16'h0042, 16'h0002, 16'h0002, 16'h0000);
    write_cfg(CfgPenEnable, 1'b1);
    send_event(mct_pkg::REQ_CANCEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
  endtask

  // contact lifecycles on a small id pool, with some noise
  task automatic test_random(input int count);
    mct_pkg::req_t rq;
    logic [15:0] src;
    for (int n = 0; n < count; n++) begin
      no_idle = (n >= count / 2) && (n < count / 2 + 40);
      case ($urandom_range(19))
        0: rq = mct_pkg::REQ_CANCEL;
        1: rq = mct_pkg::req_t'($urandom_range(7));
        default: rq = mct_pkg::req_t'($urandom_range(5));
      endcase
      src = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(7));
      send_event(rq, src, rnd_coord(), rnd_coord(), 16'($urandom_range(1) ? $urandom
                 : $urandom_range(120)));
      if (n == count / 3) begin
        write_cfg(CfgTouchEnable, 1'($urandom));
        write_cfg(CfgPenEnable, 1'($urandom));
      end
      if (n == 2 * count / 3) begin
        write_cfg(CfgTouchEnable, 1'b1);
        write_cfg(CfgPenEnable, 1'b1);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    touch_on = 1'b1;
    pen_on = 1'b1;
    foreach (t_used[i]) t_used[i] = 1'b0;
    foreach (p_used[i]) p_used[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_enables();
    test_random(130);
    drain();
    if (errors == 0 && pending_events.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/mct_pkg.sv
rtl/mct_front.sv
rtl/mct_back.sv
rtl/multitouch_contact_tracker.sv
bench/multitouch_contact_tracker_tb.sv
